/* design/atbu_pkg.sv */
package atbu_pkg;

  // Field widths of the input item.
  localparam int unsigned KindW   = 4;
  localparam int unsigned InstrW  = 25;
  localparam int unsigned CondW   = 4;
  localparam int unsigned WordW   = 32;
  localparam int unsigned FlagsW  = 4;
  localparam int unsigned CyclesW = 2;

  // Packed widths of the stream payloads, padded to whole bytes.
  localparam int unsigned InFieldsW  = InstrW + CondW + 3 * WordW + FlagsW + 1;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 2 * WordW + 4 + CyclesW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Cycle costs.
  localparam logic [CyclesW-1:0] CyclesTaken = 2'd3;
  localparam logic [CyclesW-1:0] CyclesPlain = 2'd1;

  // Link offsets.
  localparam logic [WordW-1:0] LinkWide    = 32'd4;
  localparam logic [WordW-1:0] LinkCompact = 32'd1;

  // Branch kinds.
  typedef enum logic [KindW-1:0] {
    KIND_BX           = 4'd0,
    KIND_BLX_REG      = 4'd1,
    KIND_B            = 4'd2,
    KIND_BL           = 4'd3,
    KIND_BLX_IMM      = 4'd4,
    KIND_BX_T         = 4'd5,
    KIND_BLX_REG_T    = 4'd6,
    KIND_BCOND_T      = 4'd7,
    KIND_B_T          = 4'd8,
    KIND_BL_PREFIX_T  = 4'd9,
    KIND_BL_SUFFIX_T  = 4'd10,
    KIND_BLX_SUFFIX_T = 4'd11
  } kind_t;

  // Condition codes for the compact conditional branch.
  typedef enum logic [CondW-1:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13
  } cond_t;

  // One input item, unpacked.
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [InstrW-1:0] instr;
    logic [CondW-1:0]  cond;
    logic [WordW-1:0]  pc_value;
    logic [WordW-1:0]  lr_value;
    logic [WordW-1:0]  target_value;
    logic [FlagsW-1:0] flags;
    logic              thumb_in;
  } item_t;

  // One result item, unpacked.
  typedef struct packed {
    logic [WordW-1:0]   new_pc;
    logic               pc_write;
    logic [WordW-1:0]   new_lr;
    logic               lr_write;
    logic               thumb_out;
    logic               flush;
    logic [CyclesW-1:0] cycles;
  } result_t;

  // Evaluate a condition against N Z C V (bits 3 down to 0).
  function automatic logic cond_holds(input logic [CondW-1:0] c, input logic [FlagsW-1:0] f);
    logic n, z, cy, v, res;
    n  = f[3];
    z  = f[2];
    cy = f[1];
    v  = f[0];
    unique case (c)
      COND_EQ: res = z;
      COND_NE: res = !z;
      COND_CS: res = cy;
      COND_CC: res = !cy;
      COND_MI: res = n;
      COND_PL: res = !n;
      COND_VS: res = v;
      COND_VC: res = !v;
      COND_HI: res = cy && !z;
      COND_LS: res = !cy || z;
      COND_GE: res = (n == v);
      COND_LT: res = (n != v);
      COND_GT: res = !z && (n == v);
      COND_LE: res = z || (n != v);
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* design/arm_thumb_branch_unit.sv */
// Channel  Ports                                   Transfer when
// -------  --------------------------------------  ---------------------------
// in       in_tvalid, in_tready, in_tuser, in_tdata  in_tvalid && in_tready
// out      out_tvalid, out_tready, out_tdata        out_tvalid && out_tready
// cfg      cfg_valid, cfg_ready, cfg_data           cfg_valid && cfg_ready
//
// An item is captured in the input register on its transfer and then moves to the
// result register, from which its result is offered; one item can enter every
// cycle while the result is not stalled. The target adder, the link adder and the
// condition check sit between the two registers. rst_n (synchronous, active low)
// empties both stages and clears older_core. A stalled result holds the result
// register, and the input register then takes an item only while it is empty.
module arm_thumb_branch_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input item.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [atbu_pkg::KindW-1:0]       in_tuser,   // kind
  // instr, cond, pc_value, lr_value, target_value, flags, thumb_in, zero pad
  input  logic [atbu_pkg::InDataW-1:0]     in_tdata,
  // Result item.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // new_pc, pc_write, new_lr, lr_write, thumb_out, flush, cycles, zero pad
  output logic [atbu_pkg::OutDataW-1:0]    out_tdata,
  // Configuration: older_core.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);

  atbu_pkg::item_t   item_nxt, item_r;
  atbu_pkg::result_t res_nxt, res_r;
  logic              item_vld_r;
  logic              res_vld_r;
  logic              res_ready;
  logic              older_core_r;

  // Handshake: each stage advances when the one after it has room.
  assign res_ready = !res_vld_r || out_tready;
  assign in_tready = !item_vld_r || res_ready;
  assign cfg_ready = 1'b1;

  // Unpack the input transfer.
  always_comb begin
    item_nxt.kind         = in_tuser;
    item_nxt.instr        = in_tdata[24:0];
    item_nxt.cond         = in_tdata[28:25];
    item_nxt.pc_value     = in_tdata[60:29];
    item_nxt.lr_value     = in_tdata[92:61];
    item_nxt.target_value = in_tdata[124:93];
    item_nxt.flags        = in_tdata[128:125];
    item_nxt.thumb_in     = in_tdata[129];
  end

  // Branch evaluation: one adder for the target, one for the link value.
  always_comb begin
    logic [atbu_pkg::WordW-1:0] wide_off;
    logic [atbu_pkg::WordW-1:0] base;
    logic [atbu_pkg::WordW-1:0] offs;
    logic [atbu_pkg::WordW-1:0] sum;
    logic [atbu_pkg::WordW-1:0] link_off;
    logic [atbu_pkg::WordW-1:0] link;
    logic                       blx_kind;
    logic                       taken;
    atbu_pkg::kind_t            kind;

    kind     = atbu_pkg::kind_t'(item_r.kind);
    wide_off = {{6{item_r.instr[23]}}, item_r.instr[23:0], 2'b00};
    blx_kind = (kind == atbu_pkg::KIND_BLX_REG) || (kind == atbu_pkg::KIND_BLX_IMM) ||
               (kind == atbu_pkg::KIND_BLX_REG_T) || (kind == atbu_pkg::KIND_BLX_SUFFIX_T);

    // Target adder operands.
    base = item_r.pc_value;
    case (kind)
      atbu_pkg::KIND_B, atbu_pkg::KIND_BL: offs = wide_off;
      atbu_pkg::KIND_BLX_IMM:   offs = {wide_off[31:2], item_r.instr[24], 1'b0};
      atbu_pkg::KIND_BCOND_T:   offs = {{23{item_r.instr[7]}}, item_r.instr[7:0], 1'b0};
      atbu_pkg::KIND_B_T:       offs = {{20{item_r.instr[10]}}, item_r.instr[10:0], 1'b0};
      atbu_pkg::KIND_BL_PREFIX_T:
        offs = {{9{item_r.instr[10]}}, item_r.instr[10:0], 12'd0};
      atbu_pkg::KIND_BL_SUFFIX_T, atbu_pkg::KIND_BLX_SUFFIX_T: begin
        base = item_r.lr_value;
        offs = {20'd0, item_r.instr[10:0], 1'b0};
      end
      default: offs = '0;
    endcase
    sum = base + offs;

    // Link adder: wide forms link to PC - 4, compact forms to PC - 1.
    if (kind == atbu_pkg::KIND_BLX_REG || kind == atbu_pkg::KIND_BL ||
        kind == atbu_pkg::KIND_BLX_IMM) begin
      link_off = atbu_pkg::LinkWide;
    end else begin
      link_off = atbu_pkg::LinkCompact;
    end
    link = item_r.pc_value - link_off;

    // Defaults describe a no-op.
    res_nxt.new_pc    = item_r.pc_value;
    res_nxt.new_lr    = item_r.lr_value;
    res_nxt.lr_write  = 1'b0;
    res_nxt.thumb_out = item_r.thumb_in;
    taken             = 1'b0;

    if (!(blx_kind && older_core_r)) begin
      case (kind)
        atbu_pkg::KIND_BX, atbu_pkg::KIND_BX_T: begin
          res_nxt.new_pc    = {item_r.target_value[31:1], 1'b0};
          res_nxt.thumb_out = item_r.target_value[0];
          taken             = 1'b1;
        end
        atbu_pkg::KIND_BLX_REG, atbu_pkg::KIND_BLX_REG_T: begin
          res_nxt.new_pc    = {item_r.target_value[31:1], 1'b0};
          res_nxt.thumb_out = item_r.target_value[0];
          res_nxt.new_lr    = link;
          res_nxt.lr_write  = 1'b1;
          taken             = 1'b1;
        end
        atbu_pkg::KIND_B, atbu_pkg::KIND_B_T: begin
          res_nxt.new_pc = sum;
          taken          = 1'b1;
        end
        atbu_pkg::KIND_BL, atbu_pkg::KIND_BL_SUFFIX_T: begin
          res_nxt.new_pc   = sum;
          res_nxt.new_lr   = link;
          res_nxt.lr_write = 1'b1;
          taken            = 1'b1;
        end
        atbu_pkg::KIND_BLX_IMM: begin
          res_nxt.new_pc    = sum;
          res_nxt.new_lr    = link;
          res_nxt.lr_write  = 1'b1;
          res_nxt.thumb_out = 1'b1;
          taken             = 1'b1;
        end
        atbu_pkg::KIND_BCOND_T: begin
          if (atbu_pkg::cond_holds(item_r.cond, item_r.flags)) begin
            res_nxt.new_pc = sum;
            taken          = 1'b1;
          end
        end
        atbu_pkg::KIND_BL_PREFIX_T: begin
          res_nxt.new_lr   = sum;
          res_nxt.lr_write = 1'b1;
        end
        atbu_pkg::KIND_BLX_SUFFIX_T: begin
          res_nxt.new_pc    = {sum[31:2], 2'b00};
          res_nxt.new_lr    = link;
          res_nxt.lr_write  = 1'b1;
          res_nxt.thumb_out = 1'b0;
          taken             = 1'b1;
        end
        default: begin
        end
      endcase
    end

    res_nxt.pc_write = taken;
    res_nxt.flush    = taken;
    res_nxt.cycles   = taken ? atbu_pkg::CyclesTaken : atbu_pkg::CyclesPlain;
  end

  // Control state: stage valid bits and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r   <= 1'b0;
      res_vld_r    <= 1'b0;
      older_core_r <= 1'b0;
    end else begin
      if (in_tready) begin
        item_vld_r <= in_tvalid;
      end
      if (res_ready) begin
        res_vld_r <= item_vld_r;
      end
      if (cfg_valid && cfg_ready) begin
        older_core_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
    if (item_vld_r && res_ready) begin
      res_r <= res_nxt;
    end
  end

  // Pack the result transfer.
  assign out_tvalid = res_vld_r;
  assign out_tdata  = {{(atbu_pkg::OutDataW - atbu_pkg::OutFieldsW){1'b0}},
                       res_r.cycles, res_r.flush, res_r.thumb_out, res_r.lr_write,
                       res_r.new_lr, res_r.pc_write, res_r.new_pc};

endmodule
